// ===== rtl/sb2da_pkg.sv =====
// ----------------------------------------------------------------------------
// sb2da_pkg
// Shared types and constants for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sb2da_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned CharWidth  = 7;
	localparam int unsigned DigitWidth = 4;
	localparam int unsigned MaxDigits  = 10;
	localparam int unsigned CountWidth = 4;

	localparam logic [CharWidth-1:0] AsciiZero  = 7'd48;
	localparam logic [CharWidth-1:0] AsciiMinus = 7'd45;

	// floor(x * RecipTen / 2^35) equals floor(x / 10) for every 32-bit x.
	localparam logic [31:0] RecipTen   = 32'hCCCC_CCCD;
	localparam int unsigned RecipShift = 35;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic pop;
		logic sel_minus;
	} dp_cmd_t;

	typedef struct packed {
		logic quo_zero;
		logic negative;
		logic one_left;
	} dp_sts_t;

endpackage

// ===== rtl/sb2da_dp.sv =====
// ----------------------------------------------------------------------------
// sb2da_dp
// Datapath: magnitude register, divide-by-ten step and a digit stack.
// ----------------------------------------------------------------------------
module sb2da_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sb2da_pkg::dp_cmd_t                   cmd,
	output sb2da_pkg::dp_sts_t                   sts,
	input  logic signed [sb2da_pkg::ValueWidth-1:0] value,
	output logic [sb2da_pkg::CharWidth-1:0]      character
);

	logic [sb2da_pkg::ValueWidth-1:0]   mag_q;
	logic                               neg_q;
	logic [sb2da_pkg::CountWidth-1:0]   cnt_q;
	logic [sb2da_pkg::DigitWidth-1:0]   dig_q [sb2da_pkg::MaxDigits];

	logic [2*sb2da_pkg::ValueWidth-1:0] prod;
	logic [sb2da_pkg::ValueWidth-1:0]   quo;
	logic [sb2da_pkg::ValueWidth-1:0]   quo_x10;
	logic [sb2da_pkg::ValueWidth-1:0]   rem_full;
	logic [sb2da_pkg::DigitWidth-1:0]   rem;

	always_comb begin
		prod     = {32'd0, mag_q} * {32'd0, sb2da_pkg::RecipTen};
		quo      = 32'(prod >> sb2da_pkg::RecipShift);
		quo_x10  = (quo << 3) + (quo << 1);
		rem_full = mag_q - quo_x10;
		rem      = rem_full[sb2da_pkg::DigitWidth-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.pop) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// The newest digit enters at the bottom of the stack, so once the
	// conversion ends the most significant digit sits at entry zero.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[sb2da_pkg::ValueWidth-1];
			mag_q <= value[sb2da_pkg::ValueWidth-1] ? (32'd0 - 32'(value)) : 32'(value);
		end else if (cmd.step) begin
			mag_q <= quo;
		end
		if (cmd.step) begin
			dig_q[0] <= rem;
			for (int i = 1; i < sb2da_pkg::MaxDigits; i++) begin
				dig_q[i] <= dig_q[i-1];
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < sb2da_pkg::MaxDigits - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
		end
	end

	always_comb begin
		sts.quo_zero = (quo == '0);
		sts.negative = neg_q;
		sts.one_left = (cnt_q == 4'd1);
		if (cmd.sel_minus) begin
			character = sb2da_pkg::AsciiMinus;
		end else begin
			character = sb2da_pkg::AsciiZero + {3'd0, dig_q[0]};
		end
	end

endmodule

// ===== rtl/sb2da_ctrl.sv =====
// ----------------------------------------------------------------------------
// sb2da_ctrl
// Controller: sequences load, conversion, sign and digit emission.
// ----------------------------------------------------------------------------
module sb2da_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  sb2da_pkg::dp_sts_t sts,
	output sb2da_pkg::dp_cmd_t cmd,
	output logic               busy,
	output logic               char_valid,
	output logic               last_char
);

	sb2da_pkg::state_t state_q;
	sb2da_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sb2da_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sb2da_pkg::ST_IDLE: begin
				if (start) state_nxt = sb2da_pkg::ST_CONV;
			end
			sb2da_pkg::ST_CONV: begin
				if (sts.quo_zero) begin
					state_nxt = sts.negative ? sb2da_pkg::ST_SIGN : sb2da_pkg::ST_EMIT;
				end
			end
			sb2da_pkg::ST_SIGN: begin
				state_nxt = sb2da_pkg::ST_EMIT;
			end
			sb2da_pkg::ST_EMIT: begin
				if (sts.one_left) state_nxt = sb2da_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = sb2da_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		busy       = 1'b1;
		char_valid = 1'b0;
		last_char  = 1'b0;
		case (state_q)
			sb2da_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			sb2da_pkg::ST_CONV: begin
				cmd.step = 1'b1;
			end
			sb2da_pkg::ST_SIGN: begin
				cmd.sel_minus = 1'b1;
				char_valid    = 1'b1;
			end
			sb2da_pkg::ST_EMIT: begin
				cmd.pop    = 1'b1;
				char_valid = 1'b1;
				last_char  = sts.one_left;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/signed_binary_to_decimal_ascii_top.sv =====
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_top
// Converts a signed 32-bit integer into its decimal ASCII character stream.
// ----------------------------------------------------------------------------
// A value is taken on a rising edge where start is high and busy is low.
// Its text leaves as one character per cycle on character, marked by
// char_valid; last_char is high on the final character. A negative value
// opens with '-', digits follow most significant first, zero gives '0'.
// Each character is shown for exactly one cycle and the receiver cannot
// stall the stream, so it must take every character flagged by char_valid.
// A conversion runs the divide-by-ten step (one reciprocal multiply per
// digit), then shows the minus sign when the value is negative, then the
// digits. busy stays high from the transfer until the last character has
// been shown, so a new value is taken only after the previous text.
// Reset returns the controller to idle and drops any conversion in flight.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [sb2da_pkg::ValueWidth-1:0] value,
	output logic [sb2da_pkg::CharWidth-1:0]         character,
	output logic                                    last_char,
	output logic                                    char_valid
);

	sb2da_pkg::dp_cmd_t cmd;
	sb2da_pkg::dp_sts_t sts;

	sb2da_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy),
		.char_valid (char_valid),
		.last_char  (last_char)
	);

	sb2da_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.character (character)
	);

endmodule

// ===== rtl/sb2da_chk.sv =====
// ----------------------------------------------------------------------------
// sb2da_chk
// Port-level checker for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module sb2da_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic [sb2da_pkg::CharWidth-1:0] character,
	input logic                            last_char,
	input logic                            char_valid
);

	// An accepted transfer always starts a conversion.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted value");

	// The block only goes idle right after the last character of a run.
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(char_valid && last_char))
		else $error("busy fell without a final character");

	// Characters are produced only while a conversion is in progress.
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> busy)
		else $error("character strobe while idle");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		last_char |-> char_valid)
		else $error("last_char without a character");

	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (character == sb2da_pkg::AsciiMinus) ||
			(character >= sb2da_pkg::AsciiZero && character <= 7'd57))
		else $error("character is neither a digit nor a minus sign");

endmodule

bind signed_binary_to_decimal_ascii_top sb2da_chk u_sb2da_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.character  (character),
	.last_char  (last_char),
	.char_valid (char_valid)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the signed binary to decimal ASCII converter. Values are sent
// as command transfers: directed, bursts with random gaps, back to back, drained.
// Every character strobe is checked against a local prediction of the expected text.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned DrainWait  = 40;

	typedef struct packed {
		logic [sb2da_pkg::CharWidth-1:0] ch;
		logic                            last;
	} text_char_t;

	logic                                    clk = 1'b0;
	logic                                    arst_n = 1'b0;
	logic                                    start = 1'b0;
	logic signed [sb2da_pkg::ValueWidth-1:0] value = '0;
	logic                                    busy;
	logic [sb2da_pkg::CharWidth-1:0]         character;
	logic                                    last_char;
	logic                                    char_valid;

	text_char_t  text_q[$];
	int unsigned values_sent = 0;
	int unsigned chars_seen = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	signed_binary_to_decimal_ascii_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.character  (character),
		.last_char  (last_char),
		.char_valid (char_valid)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// Appends the expected decimal text of one value to the queue.
	task automatic predict_text(input logic [sb2da_pkg::ValueWidth-1:0] raw);
		logic                             negative;
		logic [sb2da_pkg::ValueWidth-1:0] mag;
		logic [sb2da_pkg::ValueWidth-1:0] rem;
		logic [sb2da_pkg::DigitWidth-1:0] digits[sb2da_pkg::MaxDigits];
		int                               nd;
		text_char_t                       c;
		negative = raw[sb2da_pkg::ValueWidth-1];
		mag = negative ? (~raw + 1'b1) : raw;
		nd = 0;
		do begin
			rem = mag % 10;
			digits[nd] = rem[sb2da_pkg::DigitWidth-1:0];
			mag = mag / 10;
			nd++;
		end while (mag != 0 && nd < sb2da_pkg::MaxDigits);
		if (negative) begin
			c.ch = sb2da_pkg::AsciiMinus;
			c.last = 1'b0;
			text_q.push_back(c);
		end
		for (int k = nd - 1; k >= 0; k--) begin
			c.ch = sb2da_pkg::AsciiZero + {3'd0, digits[k]};
			c.last = (k == 0);
			text_q.push_back(c);
		end
	endtask

	// Character checker: the receiver cannot stall, so every strobe is taken.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && char_valid) begin
			chars_seen++;
			if (text_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected character %0d last %0b", character, last_char);
			end else begin
				want = text_q.pop_front();
				if (character !== want.ch || last_char !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected char %0d last %0b, got char %0d last %0b",
							want.ch, want.last, character, last_char);
				end
			end
		end
	end

	// Leaves start high after the transfer so a following value can go back to back.
	task automatic send_value(input logic [sb2da_pkg::ValueWidth-1:0] v);
		@(negedge clk);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		predict_text(v);
		values_sent++;
	endtask

	task automatic pause_sender(input int unsigned n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		pause_sender(1);
		while (text_q.size() != 0) @(posedge clk);
	endtask

	// Picks a value with a random digit count so that every run length is common.
	function automatic logic [sb2da_pkg::ValueWidth-1:0] random_value();
		int unsigned mode;
		int unsigned ndig;
		longint      lo;
		longint      hi;
		longint      mag;
		logic        negative;
		mode = $urandom_range(0, 9);
		negative = $urandom_range(0, 1);
		ndig = $urandom_range(1, 10);
		lo = 1;
		for (int i = 1; i < ndig; i++)
			lo = lo * 10;
		if (mode < 2)
			return $urandom;
		if (mode == 2) begin
			// Just below or at a power of ten: the digit count changes here.
			mag = lo - longint'($urandom_range(0, 1));
		end else begin
			hi = (ndig == 10) ? (negative ? 64'd2147483648 : 64'd2147483647) : lo * 10 - 1;
			if (ndig == 1)
				lo = 0;
			mag = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
		end
		if (negative)
			mag = -mag;
		return mag[sb2da_pkg::ValueWidth-1:0];
	endfunction

	task automatic test_directed();
		logic [sb2da_pkg::ValueWidth-1:0] vals[$];
		vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd999999999,
			32'd1000000000, -32'sd999999999, -32'sd1000000000, 32'd123456789,
			-32'sd123456789, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd9};
		foreach (vals[i]) begin
			send_value(vals[i]);
			pause_sender($urandom_range(0, 3));
		end
		wait_drained();
	endtask

	task automatic test_random_bursts(input int unsigned count);
		int unsigned burst;
		while (count > 0) begin
			burst = $urandom_range(1, 12);
			if (burst > count)
				burst = count;
			repeat (burst) begin
				send_value(random_value());
				// Short gaps inside a burst land on different phases of the conversion.
				if ($urandom_range(0, 3) == 0)
					pause_sender($urandom_range(1, 24));
			end
			count -= burst;
			pause_sender($urandom_range(0, 30));
		end
	endtask

	task automatic test_back_to_back(input int unsigned count);
		repeat (count)
			send_value(random_value());
		pause_sender(1);
	endtask

	task automatic test_drain_pause(input int unsigned count);
		repeat (count) begin
			send_value(random_value());
			wait_drained();
			pause_sender($urandom_range(0, 3));
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_bursts(200);
		test_back_to_back(40);
		test_drain_pause(40);
		test_random_bursts(180);
		wait_drained();
		repeat (DrainWait) @(posedge clk);
		$display("Converted %0d values in directed, burst, back-to-back and drained phases,",
			values_sent);
		$display("checking %0d characters with %0d mismatches.", chars_seen, mismatches);
		if (mismatches == 0 && text_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sb2da_pkg.sv
rtl/sb2da_dp.sv
rtl/sb2da_ctrl.sv
rtl/signed_binary_to_decimal_ascii_top.sv
rtl/sb2da_chk.sv
test/tb_top.sv
